[hdl/tsdf_pkg.sv]
// Shared types and constants for the two-segment length-prefix deframer.
package tsdf_pkg;

  // Parse phases, in stream order
  typedef enum logic [2:0] {
    PH_DATA_HDR = 3'd0,
    PH_DATA     = 3'd1,
    PH_FW_HDR   = 3'd2,
    PH_FW       = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  // Byte classification codes on the result word
  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_FW      = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_t;

  // Only the first four header bytes form the 32-bit length
  localparam int LEN_W       = 32;
  localparam int HDR_USED    = 4;
  localparam int SHIFT_W     = 24;

  // Input word as held in the input register
  typedef struct packed {
    logic       restart;
    logic [7:0] stream_byte;
  } in_word_t;

  // Result word as held in the output register
  typedef struct packed {
    kind_t             byte_kind;
    logic [7:0]        byte_value;
    logic [LEN_W-1:0]  region_offset;
    logic              length_ready;
    logic [LEN_W-1:0]  announced_length;
    logic              segment_complete;
    logic              transfer_done;
  } res_word_t;

endpackage

[hdl/tsdf_in_stage.sv]
// Input register stage: captures one accepted input word.
module tsdf_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              drain,
  input  tsdf_pkg::in_word_t word_in,
  output logic              vld,
  output tsdf_pkg::in_word_t word_out
);
  import tsdf_pkg::*;

  logic     vld_r, vld_nxt;
  in_word_t word_r;

  // occupancy: set on load, cleared when the word moves on
  always_comb begin
    vld_nxt = vld_r;
    if (drain) vld_nxt = 1'b0;
    if (load)  vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_in;
    end
  end

  assign vld      = vld_r;
  assign word_out = word_r;

endmodule

[hdl/tsdf_parse.sv]
// Parse state and single-pass next-state / result logic.
module tsdf_parse #(
  parameter int LENGTH_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  tsdf_pkg::in_word_t word,
  output tsdf_pkg::res_word_t res
);
  import tsdf_pkg::*;

  localparam int HCW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
  localparam logic [HCW-1:0] HC_LAST = HCW'(LENGTH_BYTES - 1);
  // headers longer than four bytes keep all four length bytes between words
  localparam int SW = (LENGTH_BYTES > HDR_USED) ? LEN_W : SHIFT_W;

  phase_t             phase_r, phase_nxt;
  logic [HCW-1:0]     hc_r, hc_nxt;
  logic [SW-1:0]      shift_r, shift_nxt;
  logic [LEN_W-1:0]   seg_len_r, seg_len_nxt;
  logic [LEN_W-1:0]   seg_cnt_r, seg_cnt_nxt;

  // effective state after an optional restart
  phase_t             ph;
  logic [HCW-1:0]     hc;
  logic [SW-1:0]      shift;
  logic [LEN_W-1:0]   seg_len;
  logic [LEN_W-1:0]   seg_cnt;

  logic [3:0]         hc_w;
  logic [LEN_W-1:0]   acc;
  logic [LEN_W-1:0]   cnt_inc;
  logic               hdr_last;

  always_comb begin
    if (word.restart) begin
      ph = PH_DATA_HDR; hc = '0; shift = '0; seg_len = '0; seg_cnt = '0;
    end else begin
      ph = phase_r; hc = hc_r; shift = shift_r; seg_len = seg_len_r; seg_cnt = seg_cnt_r;
    end
  end

  // little-endian accumulate of the current header byte
  always_comb begin
    hc_w = 4'(hc);
    acc  = LEN_W'(shift);
    for (int i = 0; i < HDR_USED; i++) begin
      if (hc_w == 4'(i)) acc = acc | (LEN_W'(word.stream_byte) << (8 * i));
    end
  end

  assign hdr_last = (hc == HC_LAST);
  assign cnt_inc  = seg_cnt + LEN_W'(1);

  // next state and result word
  always_comb begin
    phase_nxt   = ph;
    hc_nxt      = hc;
    shift_nxt   = shift;
    seg_len_nxt = seg_len;
    seg_cnt_nxt = seg_cnt;

    res.byte_kind        = KIND_DISCARD;
    res.byte_value       = word.stream_byte;
    res.region_offset    = '0;
    res.length_ready     = 1'b0;
    res.announced_length = '0;
    res.segment_complete = 1'b0;

    case (ph)
      PH_DATA_HDR, PH_FW_HDR: begin
        res.byte_kind     = KIND_HDR;
        res.region_offset = LEN_W'(hc);
        if (hdr_last) begin
          hc_nxt               = '0;
          shift_nxt            = '0;
          seg_len_nxt          = acc;
          seg_cnt_nxt          = '0;
          res.length_ready     = 1'b1;
          res.announced_length = acc;
          if (acc == '0) begin
            res.segment_complete = 1'b1;
            phase_nxt = (ph == PH_DATA_HDR) ? PH_FW_HDR : PH_DONE;
          end else begin
            phase_nxt = (ph == PH_DATA_HDR) ? PH_DATA : PH_FW;
          end
        end else begin
          hc_nxt    = hc + HCW'(1);
          shift_nxt = acc[SW-1:0];
        end
      end
      PH_DATA, PH_FW: begin
        res.byte_kind     = (ph == PH_DATA) ? KIND_DATA : KIND_FW;
        res.region_offset = seg_cnt;
        seg_cnt_nxt       = cnt_inc;
        if (cnt_inc == seg_len) begin
          res.segment_complete = 1'b1;
          phase_nxt = (ph == PH_DATA) ? PH_FW_HDR : PH_DONE;
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    res.transfer_done = (phase_nxt == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_DATA_HDR;
      hc_r      <= '0;
      shift_r   <= '0;
      seg_len_r <= '0;
      seg_cnt_r <= '0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      hc_r      <= hc_nxt;
      shift_r   <= shift_nxt;
      seg_len_r <= seg_len_nxt;
      seg_cnt_r <= seg_cnt_nxt;
    end
  end

endmodule

[hdl/tsdf_out_stage.sv]
// Output register stage: holds one result word until it is taken.
module tsdf_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                stall,
  input  tsdf_pkg::res_word_t word_in,
  output logic                vld,
  output logic                ready,
  output tsdf_pkg::res_word_t word_out
);
  import tsdf_pkg::*;

  logic      vld_r, vld_nxt;
  res_word_t word_r;

  // free when empty or when the held word leaves this cycle
  assign ready = !vld_r || !stall;

  always_comb begin
    vld_nxt = vld_r;
    if (ready) vld_nxt = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ready) begin
      word_r <= word_in;
    end
  end

  assign vld      = vld_r;
  assign word_out = word_r;

endmodule

[hdl/two_segment_length_prefix_deframer_core.sv]
// Top level of the two-segment length-prefix deframer.
// Splits a byte stream into a data region and a firmware region, each led by
// a LENGTH_BYTES-byte little-endian length (only the first four bytes count).
// Every accepted word gives exactly one result word: byte kind, the byte, its
// offset in its region (or header byte index), the length when a header
// completes, segment completion and a transfer-done flag that stays set until
// a restart. A zero length completes its segment on the header byte itself.
// in_restart clears the parse state before its byte is handled as a first
// header byte. Throughput is one word per cycle while in_stall is low. A word
// passes two registers (input register, then the parse logic into the output
// register): out_valid for its result rises once the word is in the output
// register, and the result is taken on a clock edge with out_stall low. in_stall
// rises only while both stages are full and out_stall is high.
module two_segment_length_prefix_deframer_core #(
  parameter int LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_byte_kind,
  output logic [7:0]  out_byte_value,
  output logic [31:0] out_region_offset,
  output logic        out_length_ready,
  output logic [31:0] out_announced_length,
  output logic        out_segment_complete,
  output logic        out_transfer_done
);
  import tsdf_pkg::*;

  in_word_t  in_word, s1_word;
  res_word_t s2_in, s2_word;
  logic      s1_vld, s2_ready, s1_take, in_take;

  assign in_word.restart     = in_restart;
  assign in_word.stream_byte = in_stream_byte;

  // handshake between the two stages
  assign s1_take  = s1_vld && s2_ready;
  assign in_stall = s1_vld && !s2_ready;
  assign in_take  = in_valid && !in_stall;

  tsdf_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_take),
    .drain    (s1_take),
    .word_in  (in_word),
    .vld      (s1_vld),
    .word_out (s1_word)
  );

  tsdf_parse #(
    .LENGTH_BYTES (LENGTH_BYTES)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (s1_take),
    .word  (s1_word),
    .res   (s2_in)
  );

  tsdf_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s1_vld),
    .stall    (out_stall),
    .word_in  (s2_in),
    .vld      (out_valid),
    .ready    (s2_ready),
    .word_out (s2_word)
  );

  // result word onto the ports
  assign out_byte_kind        = s2_word.byte_kind;
  assign out_byte_value       = s2_word.byte_value;
  assign out_region_offset    = s2_word.region_offset;
  assign out_length_ready     = s2_word.length_ready;
  assign out_announced_length = s2_word.announced_length;
  assign out_segment_complete = s2_word.segment_complete;
  assign out_transfer_done    = s2_word.transfer_done;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the two-segment length-prefix deframer core.
`timescale 1ns / 1ps

module tb_top;
  import tsdf_pkg::*;

  localparam int HDR_BYTES = 4;
  localparam int ITEM_TARGET = 750;
  localparam int QUIET_FROM = 640;
  localparam int CYCLE_LIMIT = 200000;

  // Predicts deframer results and matches them against the output stream
  class deframe_scoreboard;
    phase_t      phase;
    int          hdr_idx;
    logic [31:0] len_acc;
    logic [31:0] dseg_len, data_cnt, fw_len, fw_cnt;
    res_word_t   due_results[$];
    int          mismatches;

    function new();
      mismatches = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase    = PH_DATA_HDR;
      hdr_idx  = 0;
      len_acc  = '0;
      dseg_len = '0;
      data_cnt = '0;
      fw_len   = '0;
      fw_cnt   = '0;
    endfunction

    // Advance the parser by one accepted word and queue its result
    function void note_byte(logic rs, logic [7:0] b);
      res_word_t r;
      r = '0;
      r.byte_kind = KIND_DISCARD;
      r.byte_value = b;
      if (rs) clear_parse();
      case (phase)
        PH_DATA_HDR, PH_FW_HDR: begin
          r.byte_kind = KIND_HDR;
          r.region_offset = 32'(hdr_idx);
          if (hdr_idx < HDR_USED) len_acc = len_acc | (32'(b) << (8 * hdr_idx));
          hdr_idx++;
          if (hdr_idx >= HDR_BYTES) begin
            r.length_ready = 1'b1;
            r.announced_length = len_acc;
            if (phase == PH_DATA_HDR) begin
              dseg_len = len_acc;
              data_cnt = '0;
              // zero length closes the segment on the header byte
              if (len_acc == 0) begin
                r.segment_complete = 1'b1;
                phase = PH_FW_HDR;
              end else begin
                phase = PH_DATA;
              end
            end else begin
              fw_len = len_acc;
              fw_cnt = '0;
              if (len_acc == 0) begin
                r.segment_complete = 1'b1;
                phase = PH_DONE;
              end else begin
                phase = PH_FW;
              end
            end
            hdr_idx = 0;
            len_acc = '0;
          end
        end
        PH_DATA: begin
          r.byte_kind = KIND_DATA;
          r.region_offset = data_cnt;
          data_cnt = data_cnt + 1;
          if (data_cnt == dseg_len) begin
            r.segment_complete = 1'b1;
            phase = PH_FW_HDR;
          end
        end
        PH_FW: begin
          r.byte_kind = KIND_FW;
          r.region_offset = fw_cnt;
          fw_cnt = fw_cnt + 1;
          if (fw_cnt == fw_len) begin
            r.segment_complete = 1'b1;
            phase = PH_DONE;
          end
        end
        default: phase = PH_DONE;
      endcase
      r.transfer_done = (phase == PH_DONE);
      due_results.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(res_word_t act);
      res_word_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual %0h", $time, act);
        return;
      end
      want = due_results.pop_front();
      field_check("byte_kind", 32'(want.byte_kind), 32'(act.byte_kind));
      field_check("byte_value", 32'(want.byte_value), 32'(act.byte_value));
      field_check("region_offset", want.region_offset, act.region_offset);
      field_check("length_ready", 32'(want.length_ready), 32'(act.length_ready));
      field_check("announced_length", want.announced_length, act.announced_length);
      field_check("segment_complete", 32'(want.segment_complete),
                  32'(act.segment_complete));
      field_check("transfer_done", 32'(want.transfer_done), 32'(act.transfer_done));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_restart;
  logic [7:0]  in_stream_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_byte_kind;
  logic [7:0]  out_byte_value;
  logic [31:0] out_region_offset;
  logic        out_length_ready;
  logic [31:0] out_announced_length;
  logic        out_segment_complete;
  logic        out_transfer_done;

  deframe_scoreboard sb;
  int  words_sent;
  int  cycles;
  bit  quiet;

  two_segment_length_prefix_deframer_core #(
    .LENGTH_BYTES(HDR_BYTES)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_restart          (in_restart),
    .in_stream_byte      (in_stream_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte_kind       (out_byte_kind),
    .out_byte_value      (out_byte_value),
    .out_region_offset   (out_region_offset),
    .out_length_ready    (out_length_ready),
    .out_announced_length(out_announced_length),
    .out_segment_complete(out_segment_complete),
    .out_transfer_done   (out_transfer_done)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    res_word_t act;
    if (rst_n && out_valid && !out_stall) begin
      act.byte_kind = kind_t'(out_byte_kind);
      act.byte_value = out_byte_value;
      act.region_offset = out_region_offset;
      act.length_ready = out_length_ready;
      act.announced_length = out_announced_length;
      act.segment_complete = out_segment_complete;
      act.transfer_done = out_transfer_done;
      sb.check_result(act);
    end
  end

  // Receiver back-pressure in random bursts, off in the quiet tail
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 30)) @(negedge clk);
      end
    end
  end

  // Drive one word; called at a falling edge, returns at a falling edge
  task automatic send_word(input logic rs, input logic [7:0] b);
    in_valid <= 1'b1;
    in_restart <= rs;
    in_stream_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(rs, b);
    words_sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // Hold off until every predicted result has been seen
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.due_results.size() != 0);
  endtask

  // Little-endian length header; first byte carries the restart flag
  task automatic send_len(input logic rs, input logic [31:0] len);
    for (int i = 0; i < HDR_BYTES; i++)
      send_word(i == 0 ? rs : 1'b0, i < 4 ? len[8*i +: 8] : 8'($urandom));
  endtask

  // Well-formed frame with random content and an occasional stray restart
  task automatic send_frame(input int dlen, input int flen, input int tail);
    send_len(1'b1, 32'(dlen));
    for (int i = 0; i < dlen; i++)
      send_word($urandom_range(0, 99) == 0, 8'($urandom));
    send_len(1'b0, 32'(flen));
    for (int i = 0; i < flen; i++)
      send_word($urandom_range(0, 99) == 0, 8'($urandom));
    for (int i = 0; i < tail; i++)
      send_word(1'b0, 8'($urandom));
  endtask

  // Stimulus
  initial begin
    bit drained_mid;
    sb = new();
    words_sent = 0;
    quiet = 1'b0;
    drained_mid = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_restart = 1'b0;
    in_stream_byte = 8'h00;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // both lengths zero: each header closes its segment, then discard
    send_len(1'b1, 32'h0);
    send_len(1'b0, 32'h0);
    send_word(1'b0, 8'hFF);
    // maximum data length, one byte in, then cut short by restart
    send_len(1'b1, 32'hFFFF_FFFF);
    send_word(1'b0, 8'hA5);
    // one data byte, one firmware byte, one discarded byte
    send_len(1'b1, 32'h1);
    send_word(1'b0, 8'h80);
    send_len(1'b0, 32'h1);
    send_word(1'b0, 8'h7F);
    send_word(1'b0, 8'h00);
    drain();

    // mostly well-formed frames, some noise with random restarts
    while (words_sent < ITEM_TARGET) begin
      if (words_sent >= QUIET_FROM) quiet = 1'b1;
      if (!drained_mid && words_sent >= ITEM_TARGET / 2) begin
        drained_mid = 1'b1;
        drain();
      end
      if ($urandom_range(0, 4) != 0) begin
        send_frame($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12),
                   $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12),
                   $urandom_range(0, 3));
      end else begin
        repeat ($urandom_range(1, 10))
          send_word($urandom_range(0, 7) == 0, 8'($urandom));
      end
    end

    // wait for the pipeline to empty, then settle
    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
